FILE: sv/d2r_pkg.sv
// Shared types and constants for the DER signature to raw r||s converter.
package d2r_pkg;

	// DER sequence tag that must open every signature
	localparam logic [7:0] SEQ_TAG = 8'h30;

	// Part width limits and reset value of the unit_size register
	localparam logic [6:0] UNIT_MAX   = 7'd64;
	localparam logic [6:0] UNIT_MIN   = 7'd1;
	localparam logic [6:0] UNIT_RESET = 7'd32;

	// Register index of unit_size on the configuration port
	localparam logic [0:0] REG_UNIT_SIZE = 1'b0;

	// Command queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// Parse position within the DER layout
	typedef enum logic [2:0] {
		PH_SEQ,
		PH_LEN,
		PH_RTAG,
		PH_RLEN,
		PH_RDATA,
		PH_STAG,
		PH_SLEN,
		PH_SDATA
	} phase_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_TAG = 2'd1,
		ST_TRUNC   = 2'd2
	} status_t;

	// Work handed from the front to the back
	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_PAD,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		status_t     status;
		logic        last;
		logic [6:0]  count;
	} cmd_t;

endpackage

FILE: sv/d2r_front.sv
// Front end: parses DER bytes and turns each into at most one back-end command.
module d2r_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // der_byte
	input  logic             s_tlast,   // der_last
	input  logic [6:0]       unit_size,
	input  logic             q_full,
	output logic             q_push,
	output d2r_pkg::cmd_t    q_cmd
);

	d2r_pkg::phase_t phase_q, phase_d;
	logic [7:0]      left_q, left_d;
	logic [7:0]      drop_q, drop_d;
	logic            discard_q, discard_d;

	logic [6:0]      unit_eff;
	logic [7:0]      left_dec;
	logic            accept;
	logic            has_cmd;
	logic            complete;
	logic            bad_tag;
	d2r_pkg::cmd_t   cmd;

	// Clamp the part width into its legal range
	always_comb begin
		if (unit_size == 7'd0) begin
			unit_eff = d2r_pkg::UNIT_MIN;
		end else if (unit_size > d2r_pkg::UNIT_MAX) begin
			unit_eff = d2r_pkg::UNIT_MAX;
		end else begin
			unit_eff = unit_size;
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign left_dec = left_q - 8'd1;

	// Decode the byte against the parse position
	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		drop_d    = drop_q;
		discard_d = discard_q;
		has_cmd   = 1'b0;
		complete  = 1'b0;
		bad_tag   = 1'b0;
		cmd.kind   = d2r_pkg::CMD_DATA;
		cmd.data   = s_tdata;
		cmd.status = d2r_pkg::ST_OK;
		cmd.last   = 1'b0;
		cmd.count  = 7'd0;

		if (!discard_q) begin
			case (phase_q)
				d2r_pkg::PH_SEQ: begin
					if (s_tdata != d2r_pkg::SEQ_TAG) begin
						bad_tag = 1'b1;
					end else begin
						phase_d = d2r_pkg::PH_LEN;
					end
				end
				d2r_pkg::PH_LEN:  phase_d = d2r_pkg::PH_RTAG;
				d2r_pkg::PH_RTAG: phase_d = d2r_pkg::PH_RLEN;
				d2r_pkg::PH_STAG: phase_d = d2r_pkg::PH_SLEN;
				d2r_pkg::PH_RLEN, d2r_pkg::PH_SLEN: begin
					left_d = s_tdata;
					drop_d = (s_tdata > {1'b0, unit_eff}) ? s_tdata - {1'b0, unit_eff} : 8'd0;
					// Short part: queue a zero run ahead of the data
					if (s_tdata < {1'b0, unit_eff}) begin
						has_cmd   = 1'b1;
						cmd.kind  = d2r_pkg::CMD_PAD;
						cmd.data  = 8'd0;
						cmd.count = unit_eff - s_tdata[6:0];
						cmd.last  = (phase_q == d2r_pkg::PH_SLEN) && (s_tdata == 8'd0);
					end
					if (phase_q == d2r_pkg::PH_RLEN) begin
						phase_d = (s_tdata == 8'd0) ? d2r_pkg::PH_STAG : d2r_pkg::PH_RDATA;
					end else if (s_tdata == 8'd0) begin
						complete = 1'b1;
					end else begin
						phase_d = d2r_pkg::PH_SDATA;
					end
				end
				d2r_pkg::PH_RDATA, d2r_pkg::PH_SDATA: begin
					left_d = left_dec;
					// Drop leading bytes of an over-long part
					if (drop_q != 8'd0) begin
						drop_d = drop_q - 8'd1;
					end else begin
						has_cmd  = 1'b1;
						cmd.last = (phase_q == d2r_pkg::PH_SDATA) && (left_dec == 8'd0);
					end
					if (left_dec == 8'd0) begin
						if (phase_q == d2r_pkg::PH_RDATA) begin
							phase_d = d2r_pkg::PH_STAG;
						end else begin
							complete = 1'b1;
						end
					end
				end
				default: phase_d = d2r_pkg::PH_SEQ;
			endcase
		end

		// Resolve errors, completion and early end
		if (discard_q) begin
			if (s_tlast) begin
				discard_d = 1'b0;
				phase_d   = d2r_pkg::PH_SEQ;
			end
		end else if (bad_tag) begin
			has_cmd    = 1'b1;
			cmd.kind   = d2r_pkg::CMD_ERR;
			cmd.data   = 8'd0;
			cmd.status = d2r_pkg::ST_BAD_TAG;
			cmd.last   = 1'b1;
			phase_d    = d2r_pkg::PH_SEQ;
			left_d     = 8'd0;
			drop_d     = 8'd0;
			discard_d  = !s_tlast;
		end else if (complete) begin
			phase_d   = d2r_pkg::PH_SEQ;
			left_d    = 8'd0;
			drop_d    = 8'd0;
			discard_d = !s_tlast;
		end else if (s_tlast) begin
			has_cmd    = 1'b1;
			cmd.kind   = d2r_pkg::CMD_ERR;
			cmd.data   = 8'd0;
			cmd.status = d2r_pkg::ST_TRUNC;
			cmd.last   = 1'b1;
			cmd.count  = 7'd0;
			phase_d    = d2r_pkg::PH_SEQ;
			left_d     = 8'd0;
			drop_d     = 8'd0;
			discard_d  = 1'b0;
		end
	end

	assign q_push = accept && has_cmd;
	assign q_cmd  = cmd;

	// Advance the parser on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= d2r_pkg::PH_SEQ;
			left_q    <= 8'd0;
			drop_q    <= 8'd0;
			discard_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			drop_q    <= drop_d;
			discard_q <= discard_d;
		end
	end

endmodule

FILE: sv/d2r_queue.sv
// Short command FIFO between the parsing front and the emitting back.
module d2r_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  d2r_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output d2r_pkg::cmd_t    head
);

	localparam int PtrW = $clog2(d2r_pkg::QUEUE_DEPTH);
	localparam int CntW = $clog2(d2r_pkg::QUEUE_DEPTH + 1);

	d2r_pkg::cmd_t   mem_q [d2r_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(d2r_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(d2r_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(d2r_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/d2r_back.sv
// Back end: expands queued commands into result words behind an output register.
module d2r_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  d2r_pkg::cmd_t    q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // raw_byte
	output logic [1:0]       m_tuser,   // status
	output logic             m_tlast    // raw_last
);

	logic [6:0] pad_cnt_q;
	logic [6:0] pad_next;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic       m_tlast_q;

	logic       issue;
	logic       run_end;
	logic [7:0] out_data;
	logic [1:0] out_user;
	logic       out_last;

	assign pad_next = pad_cnt_q + 7'd1;
	assign run_end  = (pad_next == q_head.count);
	assign issue    = !q_empty && (!m_tvalid_q || m_tready);

	// Form the next result word from the queue head
	always_comb begin
		out_data = q_head.data;
		out_user = q_head.status;
		out_last = q_head.last;
		q_pop    = 1'b0;
		case (q_head.kind)
			d2r_pkg::CMD_PAD: begin
				out_data = 8'd0;
				out_last = q_head.last && run_end;
				q_pop    = issue && run_end;
			end
			d2r_pkg::CMD_DATA, d2r_pkg::CMD_ERR: begin
				q_pop = issue;
			end
			default: begin
				q_pop = issue;
			end
		endcase
	end

	// Count zero bytes within a pad run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_cnt_q <= 7'd0;
		end else if (issue && (q_head.kind == d2r_pkg::CMD_PAD)) begin
			pad_cnt_q <= run_end ? 7'd0 : pad_next;
		end
	end

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (issue) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_user;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: sv/der_signature_to_raw.sv
// Top level of the DER signature to raw r||s converter.
//
// Channel  Dir  Words                 Fields (low bit up)
// s_*      in   DER bytes             tdata: der_byte[7:0]; tlast: der_last
// m_*      out  raw r||s bytes        tdata: raw_byte[7:0]; tuser: status[1:0]; tlast: raw_last
// APB      in   register access       unit_size at byte address 0
//
// Tag, length and data bytes are each parsed as one input word. A length byte
// of a short part queues a zero run of up to the clamped unit_size bytes that
// the back emits at one byte per cycle while m_tready holds; a two-entry
// command queue lets the parser run ahead meanwhile. Reset clears the parser,
// queue and output register; unit_size returns to 32. The input stalls only
// while the queue is full, and the back stalls only on m_tready.
module der_signature_to_raw (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // der_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // raw_byte[7:0]
	output logic [1:0]  m_tuser,    // status[1:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0]     unit_size_q;
	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	d2r_pkg::cmd_t  push_cmd;
	d2r_pkg::cmd_t  q_head;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == d2r_pkg::REG_UNIT_SIZE) ? {25'd0, unit_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_size_q <= d2r_pkg::UNIT_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == d2r_pkg::REG_UNIT_SIZE)) begin
			unit_size_q <= pwdata[6:0];
		end
	end

	d2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.unit_size (unit_size_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	d2r_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	d2r_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Error words carry a zero byte and close the signature
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != d2r_pkg::ST_OK)) |-> (m_tlast && (m_tdata == 8'd0)))
		else $error("error result without last mark or with nonzero byte");

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// Status code stays within its defined values
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == d2r_pkg::ST_OK || m_tuser == d2r_pkg::ST_BAD_TAG ||
		              m_tuser == d2r_pkg::ST_TRUNC))
		else $error("undefined status code");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the DER signature to raw r||s converter.
`timescale 1ns / 100ps

// One byte of the raw signature as the block should emit it
typedef struct {
	logic [7:0]        data;
	d2r_pkg::status_t  status;
	logic              last;
} raw_word_t;

// Tracks the parser state and holds the raw words still owed by the block
class raw_scoreboard;
	raw_word_t         raw_expected[$];
	raw_word_t         step_words[$];
	logic [6:0]        unit_size;
	d2r_pkg::phase_t   phase;
	logic [7:0]        bytes_left;
	logic [7:0]        bytes_to_drop;
	logic              discarding;
	int                errors;
	int                checked;
	int                der_bytes;

	function new();
		unit_size = d2r_pkg::UNIT_RESET;
		phase = d2r_pkg::PH_SEQ;
		bytes_left = '0;
		bytes_to_drop = '0;
		discarding = 1'b0;
		errors = 0;
		checked = 0;
		der_bytes = 0;
	endfunction

	function void set_unit(logic [31:0] value);
		unit_size = value[6:0];
	endfunction

	// Clamp the register to the width the block actually uses
	function int eff_unit();
		int u;
		u = unit_size;
		if (u < d2r_pkg::UNIT_MIN) u = d2r_pkg::UNIT_MIN;
		if (u > d2r_pkg::UNIT_MAX) u = d2r_pkg::UNIT_MAX;
		return u;
	endfunction

	function int pending();
		return raw_expected.size();
	endfunction

	function void emit(logic [7:0] d, d2r_pkg::status_t st, logic lst);
		raw_word_t w;
		w.data = d;
		w.status = st;
		w.last = lst;
		step_words.push_back(w);
	endfunction

	// Load a part length and queue its leading zero pad
	function void open_part(logic [7:0] len, int u, bit mark_end);
		int l;
		int pad;
		l = len;
		bytes_left = len;
		bytes_to_drop = (l > u) ? 8'(l - u) : 8'd0;
		pad = (l < u) ? u - l : 0;
		for (int i = 0; i < pad; i++)
			emit(8'h00, d2r_pkg::ST_OK, mark_end && (i + 1 == pad));
	endfunction

	function void clear_part();
		phase = d2r_pkg::PH_SEQ;
		bytes_left = '0;
		bytes_to_drop = '0;
	endfunction

	// Predict the raw words caused by one accepted DER word
	function void note_der(logic [7:0] b, logic lst);
		int u;
		bit done;
		u = eff_unit();
		done = 1'b0;
		der_bytes++;
		step_words.delete();
		if (discarding) begin
			if (lst) begin
				discarding = 1'b0;
				phase = d2r_pkg::PH_SEQ;
			end
			return;
		end
		case (phase)
			d2r_pkg::PH_SEQ: begin
				if (b != d2r_pkg::SEQ_TAG) begin
					emit(8'h00, d2r_pkg::ST_BAD_TAG, 1'b1);
					raw_expected.push_back(step_words[0]);
					clear_part();
					discarding = !lst;
					return;
				end
				phase = d2r_pkg::PH_LEN;
			end
			d2r_pkg::PH_LEN: phase = d2r_pkg::PH_RTAG;
			d2r_pkg::PH_RTAG: phase = d2r_pkg::PH_RLEN;
			d2r_pkg::PH_RLEN: begin
				open_part(b, u, 1'b0);
				phase = (b == 8'h00) ? d2r_pkg::PH_STAG : d2r_pkg::PH_RDATA;
			end
			d2r_pkg::PH_RDATA: begin
				bytes_left = bytes_left - 8'd1;
				if (bytes_to_drop > 0) bytes_to_drop = bytes_to_drop - 8'd1;
				else emit(b, d2r_pkg::ST_OK, 1'b0);
				if (bytes_left == 0) phase = d2r_pkg::PH_STAG;
			end
			d2r_pkg::PH_STAG: phase = d2r_pkg::PH_SLEN;
			d2r_pkg::PH_SLEN: begin
				open_part(b, u, b == 8'h00);
				if (b == 8'h00) done = 1'b1;
				else phase = d2r_pkg::PH_SDATA;
			end
			d2r_pkg::PH_SDATA: begin
				bytes_left = bytes_left - 8'd1;
				if (bytes_to_drop > 0) bytes_to_drop = bytes_to_drop - 8'd1;
				else emit(b, d2r_pkg::ST_OK, bytes_left == 0);
				if (bytes_left == 0) done = 1'b1;
			end
			default: phase = d2r_pkg::PH_SEQ;
		endcase
		if (done) begin
			clear_part();
			discarding = !lst;
		end else if (lst) begin
			// early end replaces whatever this word produced
			step_words.delete();
			emit(8'h00, d2r_pkg::ST_TRUNC, 1'b1);
			clear_part();
			discarding = 1'b0;
		end
		foreach (step_words[i]) raw_expected.push_back(step_words[i]);
	endfunction

	// Compare one emitted raw word with the oldest expectation
	function void check_raw(logic [7:0] d, logic [1:0] st, logic lst);
		raw_word_t w;
		if (raw_expected.size() == 0) begin
			$display("%0t: unexpected raw word data=%h status=%0d last=%b",
				$time, d, st, lst);
			errors++;
			return;
		end
		w = raw_expected.pop_front();
		checked++;
		if (d !== w.data) begin
			$display("%0t: raw_byte expected %h actual %h", $time, w.data, d);
			errors++;
		end
		if (st !== w.status) begin
			$display("%0t: status expected %0d actual %0d", $time, w.status, st);
			errors++;
		end
		if (lst !== w.last) begin
			$display("%0t: raw_last expected %b actual %b", $time, w.last, lst);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int         CYCLE_LIMIT   = 2000000;
	localparam int         DRAIN_CYCLES  = 200;
	localparam int         LONG_STALL    = 400;
	localparam logic [7:0] INT_TAG       = 8'h02;
	localparam logic [2:0] UNIT_ADDR     = {d2r_pkg::REG_UNIT_SIZE, 2'b00};
	localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // der_byte[7:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // raw_byte[7:0]
	logic [1:0]  m_tuser;    // status[1:0]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	raw_scoreboard sb;
	logic [7:0]    sig_bytes[$];
	bit            idle_en;
	int            stall_req;
	int            cycles;
	int            signatures;
	int            settings;

	der_signature_to_raw u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d raw words outstanding",
				cycles, sb.pending());
			$display("der_signature_to_raw: mismatch");
			$finish;
		end
	end

	// Check every raw word the block hands over
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_raw(m_tdata, m_tuser, m_tlast);
	end

	// Receiver: random hold-off bursts plus the requested long stall
	initial begin : receiver
		int hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req > 0) begin
				hold = stall_req;
				stall_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready = 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 19) - 1;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Offer one DER word and hold it until the block takes it
	task send_der(logic [7:0] b, logic lst);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = lst;
		do @(posedge clk); while (!s_tready);
		sb.note_der(b, lst);
	endtask

	// Send the built signature; close marks its final word as last
	task send_signature(bit close);
		foreach (sig_bytes[i])
			send_der(sig_bytes[i], close && (i == sig_bytes.size() - 1));
		signatures++;
	endtask

	// Drop valid and let the block finish all owed words
	task wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task apb_write(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == UNIT_ADDR) sb.set_unit(value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Part length around the unit width: empty, exact, short, long
	function int pick_len(int u);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return u;
			2: return u - 1;
			3: return u + $urandom_range(1, 3);
			4, 5: return $urandom_range(1, u);
			default: return $urandom_range(0, u + 2);
		endcase
	endfunction

	// Build one random signature: mostly well formed, some cut short,
	// some with a bad sequence tag, some pure noise
	task make_signature(int u, bit force_long, output bit close);
		int kind;
		int rlen;
		int slen;
		int cut;
		logic [7:0] b;
		sig_bytes.delete();
		close = 1'b1;
		kind = force_long ? 0 : $urandom_range(0, 9);
		if (kind == 8) begin
			b = 8'($urandom_range(0, 255));
			if (b == d2r_pkg::SEQ_TAG) b = d2r_pkg::SEQ_TAG + 8'd1;
			sig_bytes.push_back(b);
			repeat ($urandom_range(0, 4)) sig_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 9) begin
			repeat ($urandom_range(1, 5)) sig_bytes.push_back(8'($urandom_range(0, 255)));
			close = 1'($urandom_range(0, 1));
		end else begin
			rlen = force_long ? $urandom_range(128, 140) : pick_len(u);
			slen = pick_len(u);
			sig_bytes.push_back(d2r_pkg::SEQ_TAG);
			sig_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: 8'(rlen + slen + 4));
			sig_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: INT_TAG);
			sig_bytes.push_back(8'(rlen));
			repeat (rlen) sig_bytes.push_back(8'($urandom_range(0, 255)));
			sig_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: INT_TAG);
			sig_bytes.push_back(8'(slen));
			repeat (slen) sig_bytes.push_back(8'($urandom_range(0, 255)));
			if (kind == 7) begin
				cut = $urandom_range(1, sig_bytes.size() - 1);
				while (sig_bytes.size() > cut) void'(sig_bytes.pop_back());
			end else if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) sig_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// One unit_size setting followed by random signatures
	task run_setting(logic [31:0] value, int quota, bit stall, bit force_long, bit quiet);
		int sent;
		bit close;
		wait_drained();
		apb_write(UNIT_ADDR, value);
		settings++;
		idle_en = !quiet;
		if (stall) stall_req = LONG_STALL;
		sent = 0;
		while (sent < quota) begin
			make_signature(sb.eff_unit(), force_long && sent == 0, close);
			sent += sig_bytes.size();
			send_signature(close);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_en = 1'b1;
		stall_req = 0;
		signatures = 0;
		settings = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad sequence tag closed at once, then one discarded up to last
		sig_bytes = '{8'h31};
		send_signature(1'b1);
		sig_bytes = '{8'h00, 8'hFF};
		send_signature(1'b1);

		// short r at the reset width, then narrow the unit before s
		sig_bytes = '{d2r_pkg::SEQ_TAG, 8'h06, INT_TAG, 8'h01, 8'hFF};
		send_signature(1'b0);
		wait_drained();
		apb_write(UNIT_ADDR, 32'd1);
		sig_bytes = '{INT_TAG, 8'h01, 8'h80};
		send_signature(1'b1);

		// empty r and s, followed by trailing words
		sig_bytes = '{d2r_pkg::SEQ_TAG, 8'h04, INT_TAG, 8'h00, INT_TAG, 8'h00, 8'hFF, 8'h00};
		send_signature(1'b1);

		// input ends inside r
		sig_bytes = '{d2r_pkg::SEQ_TAG, 8'h05, INT_TAG, 8'h03, 8'h11, 8'h22};
		send_signature(1'b1);

		run_setting(32'd1, 40, 1'b0, 1'b0, 1'b0);
		run_setting(32'd64, 1, 1'b1, 1'b1, 1'b0);
		run_setting(32'd0, 30, 1'b0, 1'b0, 1'b0);
		wait_drained();
		apb_write(UNMAPPED_ADDR, $urandom);
		run_setting($urandom_range(2, 63), 30, 1'b0, 1'b0, 1'b0);
		run_setting({16'($urandom_range(0, 65535)), 16'd0} | 32'd100, 1, 1'b0, 1'b0, 1'b0);
		run_setting($urandom_range(1, 127), 20, 1'b0, 1'b0, 1'b0);
		run_setting(32'd32, 30, 1'b0, 1'b0, 1'b1);

		wait_drained();
		if (sb.pending() != 0) begin
			$display("%0t: %0d raw words never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("covered %0d DER words in %0d signatures over %0d unit_size settings",
			sb.der_bytes, signatures, settings);
		$display("checked %0d raw words, %0d errors", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("der_signature_to_raw: match");
		end else begin
			$display("der_signature_to_raw: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/d2r_pkg.sv
sv/d2r_front.sv
sv/d2r_queue.sv
sv/d2r_back.sv
sv/der_signature_to_raw.sv
tb/testbench.sv
